// ===== design/hhn_pkg.sv =====
package hhn_pkg;

  localparam longint VLimit  = 64'sd13107200;
  localparam longint VSpan   = 64'sd26214400;
  localparam longint Q16One  = 64'sd65536;
  localparam longint Ln2Q16  = 64'sd45426;
  localparam int     GateMax = 65535;
  localparam int     SpanDiv = 400;
  localparam logic [23:0] RecipM = 24'd10737418;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_G_NA  = 3'd0,
    REG_G_K   = 3'd1,
    REG_G_L   = 3'd2,
    REG_E_NA  = 3'd3,
    REG_E_K   = 3'd4,
    REG_E_L   = 3'd5,
    REG_DT    = 3'd6,
    REG_INV_C = 3'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_SQUARE,
    CMD_CUBE,
    CMD_MIX,
    CMD_COND,
    CMD_CURR,
    CMD_SUM,
    CMD_SCALE,
    CMD_VOLT,
    CMD_SPAN,
    CMD_RECIP,
    CMD_INDEX,
    CMD_LOOKUP,
    CMD_RATE,
    CMD_DIFF,
    CMD_DELTA,
    CMD_CLAMP,
    CMD_COMMIT
  } cmd_e;

  typedef enum int {
    RT_AM = 0,
    RT_BM = 1,
    RT_AH = 2,
    RT_BH = 3,
    RT_AN = 4,
    RT_BN = 5
  } rate_sel_e;

  typedef struct packed {
    cmd_e cmd;
    logic load;
  } dp_ctrl_t;

  function automatic logic [31:0] sat_u32(input longint v);
    logic [31:0] res;
    if (v < 0) res = 32'd0;
    else if (v > 64'sd4294967295) res = 32'hFFFF_FFFF;
    else res = v[31:0];
    return res;
  endfunction

  // shift-and-subtract quotient, used only while building the rate tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_q32(input longint x);
    longint k;
    longint r;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] res;
    if (x >= 0) k = x / Ln2Q16;
    else k = -((-x + Ln2Q16 - 1) / Ln2Q16);
    r = x - k * Ln2Q16;
    sum = 64'd1 << 32;
    term = 64'd1 << 32;
    term = (term * 64'(r)) >> 16;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd2;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd3;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd4;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd5;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd6;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd7;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd8;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd9;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd10;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd11;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd12;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd13;
    sum = sum + term;
    term = ((term * 64'(r)) >> 16) / 64'd14;
    sum = sum + term;
    if (k >= 0) begin
      if (k > 29) res = 64'd1 << 62;
      else res = sum << k;
    end else begin
      if (-k >= 63) res = 64'd0;
      else res = sum >> (-k);
    end
    return res;
  endfunction

  function automatic logic [31:0] x_over_expm1(input longint x);
    longint d;
    longint n;
    logic [63:0] q;
    logic neg;
    logic [31:0] res;
    d = longint'(exp_q32(x)) - (64'sd1 <<< 32);
    if (x == 0 || d == 0) begin
      res = 32'd65536;
    end else begin
      n = x * 64'sd4294967296;
      neg = (n < 0) != (d < 0);
      q = udiv64((n < 0) ? -n : n, (d < 0) ? -d : d);
      res = sat_u32(neg ? -longint'(q) : longint'(q));
    end
    return res;
  endfunction

  function automatic logic [31:0] rate_entry(input int sel, input longint v);
    longint u;
    logic [63:0] e;
    logic [31:0] res;
    u = v + 65 * Q16One;
    case (sel)
      RT_AM: res = x_over_expm1((25 * Q16One - u) / 10);
      RT_BM: begin
        e = exp_q32(-u / 18);
        res = sat_u32(longint'((e >> 16) * 64'd4));
      end
      RT_AH: begin
        e = exp_q32(-u / 20);
        res = sat_u32(longint'(((e >> 16) * 64'd7) / 64'd100));
      end
      RT_BH: begin
        e = exp_q32((30 * Q16One - u) / 10);
        res = sat_u32(longint'(udiv64(64'd1 << 48, e + (64'd1 << 32))));
      end
      RT_AN: res = x_over_expm1((10 * Q16One - u) / 10) / 32'd10;
      default: begin
        e = exp_q32(-u / 80);
        res = sat_u32(longint'((e >> 16) >> 3));
      end
    endcase
    return res;
  endfunction

endpackage

// ===== design/hhn_ctrl.sv =====
module hhn_ctrl
  import hhn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  state_e state_q;
  cmd_e   cmd_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign ctrl_o.cmd  = cmd_q;
  assign ctrl_o.load = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_q == CMD_COMMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RUN;
            cmd_q   <= CMD_SQUARE;
          end else begin
            cmd_q <= CMD_NONE;
          end
        end
        ST_RUN: begin
          case (cmd_q)
            CMD_SQUARE: cmd_q <= CMD_CUBE;
            CMD_CUBE:   cmd_q <= CMD_MIX;
            CMD_MIX:    cmd_q <= CMD_COND;
            CMD_COND:   cmd_q <= CMD_CURR;
            CMD_CURR:   cmd_q <= CMD_SUM;
            CMD_SUM:    cmd_q <= CMD_SCALE;
            CMD_SCALE:  cmd_q <= CMD_VOLT;
            CMD_VOLT:   cmd_q <= CMD_SPAN;
            CMD_SPAN:   cmd_q <= CMD_RECIP;
            CMD_RECIP:  cmd_q <= CMD_INDEX;
            CMD_INDEX:  cmd_q <= CMD_LOOKUP;
            CMD_LOOKUP: cmd_q <= CMD_RATE;
            CMD_RATE:   cmd_q <= CMD_DIFF;
            CMD_DIFF:   cmd_q <= CMD_DELTA;
            CMD_DELTA:  cmd_q <= CMD_CLAMP;
            CMD_CLAMP: begin
              if (out_free) begin
                cmd_q   <= CMD_COMMIT;
                state_q <= ST_IDLE;
              end else begin
                cmd_q   <= CMD_NONE;
                state_q <= ST_WAIT;
              end
            end
            default: cmd_q <= CMD_NONE;
          endcase
        end
        ST_WAIT: begin
          if (out_free) begin
            cmd_q   <= CMD_COMMIT;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          cmd_q   <= CMD_NONE;
        end
      endcase
    end
  end

endmodule

// ===== design/hhn_dp.sv =====
module hhn_dp
  import hhn_pkg::*;
#(
  parameter int RATE_TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_ctrl_t            ctrl_i,
  input  logic [InDataW-1:0]  stim_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int IdxW = $clog2(RATE_TABLE_DEPTH);

  typedef logic [31:0] rom_t [RATE_TABLE_DEPTH];

  function automatic rom_t build_rom(input int sel);
    rom_t r;
    for (int i = 0; i < RATE_TABLE_DEPTH; i++) begin
      r[i] = rate_entry(sel, -VLimit + (longint'(i) * VSpan) / RATE_TABLE_DEPTH);
    end
    return r;
  endfunction

  localparam rom_t AmRom = build_rom(RT_AM);
  localparam rom_t BmRom = build_rom(RT_BM);
  localparam rom_t AhRom = build_rom(RT_AH);
  localparam rom_t BhRom = build_rom(RT_BH);
  localparam rom_t AnRom = build_rom(RT_AN);
  localparam rom_t BnRom = build_rom(RT_BN);

  logic [15:0]        g_na_q, g_k_q, g_l_q, inv_c_q;
  logic [15:0]        e_na_q, e_k_q, e_l_q;
  logic [12:0]        dt_q;

  logic signed [24:0] v_q;
  logic [15:0]        gate_q [3];
  logic [31:0]        tick_q;

  logic signed [23:0] stim_q;
  logic [15:0]        t_q, nn_q, n4_q, m3h_q, gna_q, gk_q;
  logic [20:0]        k8_q;
  logic signed [25:0] dna_q, dk_q, dl_q;
  logic signed [34:0] ina_q, ik_q, il_q;
  logic signed [37:0] itot_q;
  logic [36:0]        lo_q;
  logic signed [43:0] hi_q;
  logic signed [24:0] vn_q;
  logic [21:0]        x_q;
  logic [13:0]        q0_q;
  logic [IdxW-1:0]    idx_q;
  logic [31:0]        a_q [3];
  logic [31:0]        b_q [3];
  logic [48:0]        pa_q [3];
  logic [47:0]        pb_q [3];
  logic signed [33:0] r_q [3];
  logic signed [31:0] dg_q [3];
  logic [15:0]        gn_q [3];
  logic [OutDataW-1:0] out_q;

  logic signed [45:0] vsum;
  logic [25:0]        wspan;
  logic [37:0]        xprod;
  logic [45:0]        qprod;
  logic [21:0]        rem;
  logic [13:0]        qidx;
  logic signed [42:0] pna, pk, pl;
  logic signed [43:0] hprod;

  assign pna   = $signed({1'b0, gna_q}) * dna_q;
  assign pk    = $signed({1'b0, gk_q}) * dk_q;
  assign pl    = $signed({1'b0, g_l_q}) * dl_q;
  assign hprod = $signed(itot_q[37:16]) * $signed({1'b0, k8_q});
  assign vsum  = 46'(v_q) + 46'(hi_q) + $signed({25'b0, lo_q[36:16]});
  assign wspan = 26'(vn_q) + 26'(VLimit);
  assign xprod = {13'b0, wspan[24:0]} * 38'(RATE_TABLE_DEPTH);
  assign qprod = {24'b0, x_q} * {22'b0, RecipM};
  assign rem   = x_q - 22'(q0_q) * 22'(SpanDiv);
  assign qidx  = (rem >= 22'(SpanDiv)) ? q0_q + 14'd1 : q0_q;

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_na_q    <= 16'd30720;
      g_k_q     <= 16'd9216;
      g_l_q     <= 16'd77;
      e_na_q    <= 16'd12800;
      e_k_q     <= 16'hB300;
      e_l_q     <= 16'hC99D;
      dt_q      <= 13'd655;
      inv_c_q   <= 16'd256;
      v_q       <= -25'sd4259840;
      gate_q[0] <= 16'd3277;
      gate_q[1] <= 16'd39322;
      gate_q[2] <= 16'd20972;
      tick_q    <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_G_NA:  g_na_q  <= cfg_data_i;
          REG_G_K:   g_k_q   <= cfg_data_i;
          REG_G_L:   g_l_q   <= cfg_data_i;
          REG_E_NA:  e_na_q  <= cfg_data_i;
          REG_E_K:   e_k_q   <= cfg_data_i;
          REG_E_L:   e_l_q   <= cfg_data_i;
          REG_DT:    dt_q    <= cfg_data_i[12:0];
          REG_INV_C: inv_c_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctrl_i.cmd == CMD_COMMIT) begin
        v_q    <= vn_q;
        tick_q <= tick_q + 32'd1;
        for (int l = 0; l < 3; l++) begin
          gate_q[l] <= gn_q[l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      stim_q <= $signed(stim_i);
    end
    case (ctrl_i.cmd)
      CMD_SQUARE: begin
        t_q  <= 16'((32'(gate_q[0]) * 32'(gate_q[0])) >> 16);
        nn_q <= 16'((32'(gate_q[2]) * 32'(gate_q[2])) >> 16);
      end
      CMD_CUBE: begin
        t_q  <= 16'((32'(t_q) * 32'(gate_q[0])) >> 16);
        n4_q <= 16'((32'(nn_q) * 32'(nn_q)) >> 16);
      end
      CMD_MIX: begin
        m3h_q <= 16'((32'(t_q) * 32'(gate_q[1])) >> 16);
        k8_q  <= 21'((29'(dt_q) * 29'(inv_c_q)) >> 8);
      end
      CMD_COND: begin
        gna_q <= 16'((32'(g_na_q) * 32'(m3h_q)) >> 16);
        gk_q  <= 16'((32'(g_k_q) * 32'(n4_q)) >> 16);
        dna_q <= 26'(v_q) - $signed({{2{e_na_q[15]}}, e_na_q, 8'b0});
        dk_q  <= 26'(v_q) - $signed({{2{e_k_q[15]}}, e_k_q, 8'b0});
        dl_q  <= 26'(v_q) - $signed({{2{e_l_q[15]}}, e_l_q, 8'b0});
      end
      CMD_CURR: begin
        ina_q <= pna[42:8];
        ik_q  <= pk[42:8];
        il_q  <= pl[42:8];
      end
      CMD_SUM: begin
        itot_q <= 38'(stim_q) - (38'(ina_q) + 38'(ik_q) + 38'(il_q));
      end
      CMD_SCALE: begin
        lo_q <= 37'(itot_q[15:0]) * 37'(k8_q);
        hi_q <= hprod;
      end
      CMD_VOLT: begin
        if (vsum > 46'(VLimit)) vn_q <= 25'(VLimit);
        else if (vsum < -46'(VLimit)) vn_q <= -25'(VLimit);
        else vn_q <= vsum[24:0];
      end
      CMD_SPAN: begin
        x_q <= xprod[37:16];
      end
      CMD_RECIP: begin
        q0_q <= qprod[45:32];
      end
      CMD_INDEX: begin
        if (qidx > 14'(RATE_TABLE_DEPTH - 1)) idx_q <= IdxW'(RATE_TABLE_DEPTH - 1);
        else idx_q <= qidx[IdxW-1:0];
      end
      CMD_LOOKUP: begin
        a_q[0] <= AmRom[idx_q];
        b_q[0] <= BmRom[idx_q];
        a_q[1] <= AhRom[idx_q];
        b_q[1] <= BhRom[idx_q];
        a_q[2] <= AnRom[idx_q];
        b_q[2] <= BnRom[idx_q];
      end
      CMD_RATE: begin
        for (int l = 0; l < 3; l++) begin
          pa_q[l] <= 49'(a_q[l]) * 49'(17'd65536 - {1'b0, gate_q[l]});
          pb_q[l] <= 48'(b_q[l]) * 48'(gate_q[l]);
        end
      end
      CMD_DIFF: begin
        for (int l = 0; l < 3; l++) begin
          r_q[l] <= 34'(($signed({1'b0, pa_q[l]}) - $signed({2'b0, pb_q[l]})) >>> 16);
        end
      end
      CMD_DELTA: begin
        for (int l = 0; l < 3; l++) begin
          dg_q[l] <= 32'((48'(r_q[l]) * $signed({35'b0, dt_q})) >>> 16);
        end
      end
      CMD_CLAMP: begin
        for (int l = 0; l < 3; l++) begin
          if (($signed({18'b0, gate_q[l]}) + 34'(dg_q[l])) < 34'sd0) begin
            gn_q[l] <= 16'd0;
          end else if (($signed({18'b0, gate_q[l]}) + 34'(dg_q[l])) > 34'(GateMax)) begin
            gn_q[l] <= 16'(GateMax);
          end else begin
            gn_q[l] <= gate_q[l] + dg_q[l][15:0];
          end
        end
      end
      CMD_COMMIT: begin
        out_q <= {7'b0, gn_q[2], gn_q[1], gn_q[0], vn_q, tick_q};
      end
      default: ;
    endcase
  end

endmodule

// ===== design/hodgkin_huxley_neuron_step_core.sv =====
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  stim_current
// m_axis    out        m_axis_tvalid/m_axis_tready  step_index, voltage, gates m h n
// cfg       in         cfg_we_i                     register index, 16-bit value
// The result goes valid after an item is accepted and 16 datapath steps issued
// by the sequencer, then a commit step. The next item is taken in the commit step,
// so only one item is in flight at a time, and a stalled output holds off the commit.
// Reset restores model state and register defaults at once, no clearing pass.
// A stalled result holds the last step until taken, then the block commits the next.
module hodgkin_huxley_neuron_step_core
  import hhn_pkg::*;
#(
  parameter int RATE_TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [23:0] stim_current
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] step_index, [56:32] membrane_voltage, [72:57] gate_m,
  // [88:73] gate_h, [104:89] gate_n, [111:105] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dp_ctrl_t ctrl;

  hhn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  hhn_dp #(
    .RATE_TABLE_DEPTH (RATE_TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stim_i     (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while busy");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped");

  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.cmd == CMD_COMMIT) |=> m_axis_tvalid)
    else $error("commit without result");

  a_vrange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[56:32]) <= 25'sd13107200 &&
                       $signed(m_axis_tdata[56:32]) >= -25'sd13107200))
    else $error("voltage out of range");

endmodule
